[rtl/core/retry_backoff_with_jitter_macros.svh]
// ----------------------------------------------------------------------------
// Retry backoff assertion macros
// Shared property templates for the retry backoff block and its submodules.
// ----------------------------------------------------------------------------
`ifndef RETRY_BACKOFF_WITH_JITTER_MACROS_SVH
`define RETRY_BACKOFF_WITH_JITTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RBJ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RBJ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/rbj_pkg.sv]
// ----------------------------------------------------------------------------
// rbj_pkg
// Types, widths, codes and reset values shared by the retry backoff block.
// ----------------------------------------------------------------------------
package rbj_pkg;

  localparam int JITTER_FRAC_BITS = 16;

  localparam int WORD_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DELAY_W = 42;
  localparam int PROD_W  = WORD_W + FRAC_W;
  localparam int SPAN_W  = WORD_W + 1;

  // Doubling stops after this many steps; any nonzero base is past the cap.
  localparam int DOUBLE_MAX = 33;
  localparam int DBL_CNT_W  = $clog2(DOUBLE_MAX + 1);

  // Restoring remainder: one dividend bit per step.
  localparam int MOD_STEPS = WORD_W;
  localparam int MOD_CNT_W = $clog2(MOD_STEPS);

  localparam logic [FRAC_W-1:0] MS_PER_S = FRAC_W'(1000);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_FRACTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_START      = 3'd4;

  localparam logic [WORD_W-1:0] BASE_DELAY_RST  = 32'd100;
  localparam logic [WORD_W-1:0] MAX_DELAY_RST   = 32'd30000;
  localparam logic [WORD_W-1:0] RETRY_LIMIT_RST = 32'd5;
  localparam logic [FRAC_W-1:0] JITTER_FRAC_RST = 16'd13107;
  localparam logic [WORD_W-1:0] SEED_START_RST  = 32'd2463534242;

  localparam int REASON_W = 3;
  localparam logic [REASON_W-1:0] REASON_OK        = 3'd0;
  localparam logic [REASON_W-1:0] REASON_NONRETRY  = 3'd1;
  localparam logic [REASON_W-1:0] REASON_EXHAUSTED = 3'd2;
  localparam logic [REASON_W-1:0] REASON_BACKOFF   = 3'd3;
  localparam logic [REASON_W-1:0] REASON_RATELIMIT = 3'd4;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } rbj_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SPAN_W-1:0] rem;
  } rbj_mod_rsp_t;

  typedef struct packed {
    logic              load;
    logic [WORD_W-1:0] load_value;
    logic              step;
  } rbj_prng_ctrl_t;

endpackage

[rtl/core/rbj_prng.sv]
// ----------------------------------------------------------------------------
// rbj_prng
// Xorshift32 generator (shifts 13, 17, 5) with a direct seed load.
// ----------------------------------------------------------------------------
module rbj_prng
  import rbj_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rbj_prng_ctrl_t      ctrl,
  output logic [WORD_W-1:0]   seed
);

  logic [WORD_W-1:0] s1;
  logic [WORD_W-1:0] s2;
  logic [WORD_W-1:0] seed_next;

  always_comb begin
    s1        = seed ^ (seed << 13);
    s2        = s1 ^ (s1 >> 17);
    seed_next = s2 ^ (s2 << 5);
  end

  // A configuration load wins over a step; the two coincide only if seed_start is written while an item is in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_START_RST;
    end else if (ctrl.load) begin
      seed <= ctrl.load_value;
    end else if (ctrl.step) begin
      seed <= seed_next;
    end
  end

endmodule

[rtl/core/rbj_modunit.sv]
// ----------------------------------------------------------------------------
// rbj_modunit
// Restoring remainder unit: one dividend bit per cycle; a new start abandons any item in work.
// ----------------------------------------------------------------------------
`include "retry_backoff_with_jitter_macros.svh"

module rbj_modunit
  import rbj_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  rbj_mod_req_t req,
  output rbj_mod_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [MOD_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    shreg;
  logic [SPAN_W-1:0]    divisor;
  logic [SPAN_W-1:0]    rem;
  logic [SPAN_W:0]      trial;
  logic [SPAN_W:0]      diff;

  always_comb begin
    trial = {rem, shreg[WORD_W-1]};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= '0;
        shreg   <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, divisor}) begin
          rem <= diff[SPAN_W-1:0];
        end else begin
          rem <= trial[SPAN_W-1:0];
        end
        shreg <= shreg << 1;
        cnt   <= cnt + 1'b1;
        if (cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

  `RBJ_ASSERT_NOW(a_rem_below_divisor, done, rem < divisor, "remainder not below divisor")
  `RBJ_ASSERT_NEXT(a_start_goes_busy, req.start, busy && cnt == '0, "start did not begin work")
  `RBJ_ASSERT_NOW(a_done_not_busy, done, !busy, "done while still busy")

endmodule

[rtl/core/retry_backoff_with_jitter.sv]
// ----------------------------------------------------------------------------
// retry_backoff_with_jitter
// Retry decision engine: truncated exponential backoff with uniform jitter.
// ----------------------------------------------------------------------------
// Usage: one request item (op, is_ok, can_retry, attempt, server_wait) is
// taken on the in_valid/in_ready channel and yields exactly one decision item
// (do_retry, exhausted, retry_delay, reason) on the out_valid/out_ready channel.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// writing seed_start also reloads the jitter generator.
// Sequence: success, non-retryable and exhausted decisions go from acceptance
// straight to S_DONE. A backoff stays in S_DOUBLE for each doubling (at most
// 33), passes S_JMUL and S_JSAT, and then S_MODGO and S_MOD when the jitter
// spread is nonzero, since the random draw is reduced modulo the span by a
// bit-serial remainder unit. Rate-limit decisions add S_AMUL and S_AMAX for
// the shared multiplier and compare. in_ready is low while an item is in work.
// A finished decision waits in the output register while the next item is
// accepted; a new result is held back until the receiver takes the old one.
// Reset restores the configuration registers to their package defaults, reseeds the
// generator and leaves both channels empty.
// ----------------------------------------------------------------------------
`include "retry_backoff_with_jitter_macros.svh"

module retry_backoff_with_jitter
  import rbj_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic                 is_ok,
  input  logic                 can_retry,
  input  logic [WORD_W-1:0]    attempt,
  input  logic [WORD_W-1:0]    server_wait,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 do_retry,
  output logic                 exhausted,
  output logic [DELAY_W-1:0]   retry_delay,
  output logic [REASON_W-1:0]  reason
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DOUBLE,
    S_JMUL,
    S_JSAT,
    S_MODGO,
    S_MOD,
    S_AMUL,
    S_AMAX,
    S_DONE
  } state_t;

  state_t state;

  logic [WORD_W-1:0] base_delay;
  logic [WORD_W-1:0] max_delay;
  logic [WORD_W-1:0] retry_limit;
  logic [FRAC_W-1:0] jitter_fraction;

  logic                 op_r;
  logic [WORD_W-1:0]    attempt_r;
  logic [WORD_W-1:0]    retry_after_r;
  logic [WORD_W-1:0]    d;
  logic [WORD_W-1:0]    j;
  logic [DBL_CNT_W-1:0] i;
  logic [PROD_W-1:0]    prod;

  logic                res_do_retry;
  logic                res_exhausted;
  logic [DELAY_W-1:0]  res_delay;
  logic [REASON_W-1:0] res_reason;

  logic [WORD_W-1:0] mul_a;
  logic [FRAC_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              dbl_go;
  logic [WORD_W:0]   dbl;
  logic [PROD_W-1:0] j_full;
  logic [WORD_W-1:0] j_sat;
  logic              spread_on;
  logic [SPAN_W:0]   jit_sum;

  rbj_mod_req_t   mod_req;
  rbj_mod_rsp_t   mod_rsp;
  rbj_prng_ctrl_t prng_ctrl;
  logic [WORD_W-1:0] seed;

  // Shared multiplier: jitter width in S_JMUL, seconds to milliseconds later.
  always_comb begin
    if (state == S_AMUL) begin
      mul_a = retry_after_r;
      mul_b = MS_PER_S;
    end else begin
      mul_a = d;
      mul_b = jitter_fraction;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_comb begin
    dbl_go = (WORD_W'(i) < attempt_r) && (i <= DBL_CNT_W'(DOUBLE_MAX))
             && (d < max_delay) && (d != '0);
    dbl    = {d, 1'b0};
    j_full = prod >> JITTER_FRAC_BITS;
    j_sat  = (j_full > PROD_W'(d)) ? d : j_full[WORD_W-1:0];
    spread_on = (d != '0) && (j_sat != '0);
    // lo + r mod (2j + 1), where lo = d - j never underflows after saturation.
    jit_sum = SPAN_W'(d - j) + {1'b0, mod_rsp.rem};
  end

  assign in_ready = (state == S_IDLE);

  assign prng_ctrl.load       = cfg_we && (cfg_index == CFG_SEED_START);
  assign prng_ctrl.load_value = cfg_data;
  assign prng_ctrl.step       = (state == S_JSAT) && spread_on;

  assign mod_req.start    = (state == S_MODGO);
  assign mod_req.dividend = seed;
  assign mod_req.divisor  = {j, 1'b1};

  rbj_prng u_prng (
    .clk  (clk),
    .rst  (rst),
    .ctrl (prng_ctrl),
    .seed (seed)
  );

  rbj_modunit u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay      <= BASE_DELAY_RST;
      max_delay       <= MAX_DELAY_RST;
      retry_limit     <= RETRY_LIMIT_RST;
      jitter_fraction <= JITTER_FRAC_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_DELAY:      base_delay      <= cfg_data;
        CFG_MAX_DELAY:       max_delay       <= cfg_data;
        CFG_RETRY_LIMIT:     retry_limit     <= cfg_data;
        CFG_JITTER_FRACTION: jitter_fraction <= cfg_data[FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r          <= op;
            attempt_r     <= attempt;
            retry_after_r <= server_wait;
            res_do_retry  <= 1'b0;
            res_exhausted <= 1'b0;
            res_delay     <= '0;
            priority if (!op && is_ok) begin
              res_reason <= REASON_OK;
              state      <= S_DONE;
            end else if (!op && !can_retry) begin
              res_exhausted <= 1'b1;
              res_reason    <= REASON_NONRETRY;
              state         <= S_DONE;
            end else if (attempt >= retry_limit) begin
              res_exhausted <= 1'b1;
              res_reason    <= REASON_EXHAUSTED;
              state         <= S_DONE;
            end else begin
              res_do_retry <= 1'b1;
              res_reason   <= op ? REASON_RATELIMIT : REASON_BACKOFF;
              // Starting at min(base, cap) makes the final cap implicit.
              d            <= (base_delay < max_delay) ? base_delay : max_delay;
              i            <= DBL_CNT_W'(1);
              state        <= S_DOUBLE;
            end
          end
        end
        S_DOUBLE: begin
          if (dbl_go) begin
            d <= (dbl > {1'b0, max_delay}) ? max_delay : dbl[WORD_W-1:0];
            i <= i + 1'b1;
          end else begin
            state <= S_JMUL;
          end
        end
        S_JMUL: begin
          prod  <= mul_p;
          state <= S_JSAT;
        end
        S_JSAT: begin
          j <= j_sat;
          if (spread_on) begin
            state <= S_MODGO;
          end else begin
            res_delay <= DELAY_W'(d);
            state     <= op_r ? S_AMUL : S_DONE;
          end
        end
        S_MODGO: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            res_delay <= DELAY_W'(jit_sum);
            state     <= op_r ? S_AMUL : S_DONE;
          end
        end
        S_AMUL: begin
          prod  <= mul_p;
          state <= S_AMAX;
        end
        S_AMAX: begin
          if (prod[DELAY_W-1:0] > res_delay) begin
            res_delay <= prod[DELAY_W-1:0];
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            do_retry    <= res_do_retry;
            exhausted   <= res_exhausted;
            retry_delay <= res_delay;
            reason      <= res_reason;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RBJ_ASSERT_NOW(a_no_retry_no_delay, out_valid && !do_retry, retry_delay == '0, "delay without retry")
  `RBJ_ASSERT_NOW(a_exhausted_reason, out_valid && exhausted,
    reason == REASON_EXHAUSTED || reason == REASON_NONRETRY, "exhausted with wrong reason")
  `RBJ_ASSERT_NOW(a_retry_xor_exhausted, out_valid, !(do_retry && exhausted), "retry and exhausted")
  `RBJ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after accept")

endmodule
